// ===== sv/svc_pkg.sv =====
// Shared types and constants for the signed varint codec.
`timescale 1ns / 1ps

package svc_pkg;

  localparam int DATA_W          = 64;
  localparam int BYTE_W          = 8;
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_BYTES_DEF   = 10;
  localparam int CHUNK_W         = 7;
  localparam int HEAD_BITS       = 5;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [BYTE_W-1:0] HEAD_ZERO = 8'h01;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_CONT = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_val;
    logic count;
    logic emit;
    logic dec;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic idx_zero;
  } sts_t;

endpackage

// ===== sv/svc_ctrl.sv =====
// Controller state machine for the signed varint codec.
`timescale 1ns / 1ps

module svc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          mode,
  input  svc_pkg::sts_t sts,
  output logic          in_ready,
  output svc_pkg::cmd_t cmd
);

  svc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      svc_pkg::ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          if (mode == svc_pkg::MODE_ENCODE) begin
            cmd.load_val = 1'b1;
            state_next   = svc_pkg::ST_COUNT;
          end else begin
            cmd.dec = 1'b1;
          end
        end
      end
      svc_pkg::ST_COUNT: begin
        cmd.count  = 1'b1;
        state_next = svc_pkg::ST_EMIT;
      end
      svc_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.idx_zero) begin
            state_next = svc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = svc_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == svc_pkg::ST_COUNT |=> state == svc_pkg::ST_EMIT)
    else $error("count cycle not followed by emission");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != svc_pkg::ST_IDLE |-> !in_ready)
    else $error("input ready while an encode is in progress");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_val, cmd.count, cmd.emit, cmd.dec}))
    else $error("more than one datapath command in a cycle");
`endif

endmodule

// ===== sv/svc_dp.sv =====
// Datapath of the signed varint codec: encode slicer, decode accumulator, output register.
`timescale 1ns / 1ps

module svc_dp #(
  parameter int VALUE_WIDTH = svc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_BYTES   = svc_pkg::MAX_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  svc_pkg::cmd_t                cmd,
  output svc_pkg::sts_t                sts,
  input  logic [svc_pkg::DATA_W-1:0]   value_in,
  input  logic [svc_pkg::BYTE_W-1:0]   byte_in,
  input  logic                         segment_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [svc_pkg::BYTE_W-1:0]   byte_out,
  output logic [svc_pkg::DATA_W-1:0]   value_out,
  output logic                         last
);

  localparam int IDX_W = $clog2(MAX_BYTES);
  localparam int EXT_W = (svc_pkg::CHUNK_W * MAX_BYTES > VALUE_WIDTH) ?
                         svc_pkg::CHUNK_W * MAX_BYTES : VALUE_WIDTH;

  // Encode side.
  logic signed [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0]        mag;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              cnt;
  logic                          head;
  logic signed [EXT_W-1:0]       vext;
  logic [svc_pkg::CHUNK_W-1:0]   chunk;
  logic [svc_pkg::BYTE_W-1:0]    enc_byte;

  // Decode side.
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  svc_pkg::phase_t        phase, phase_next;

  // The magnitude is taken as unsigned, so the most negative value still fits.
  assign mag = val[VALUE_WIDTH-1] ? VALUE_WIDTH'(-val) : VALUE_WIDTH'(val);

  // Continuation count: the largest k below MAX_BYTES with mag >= 32 << 7*(k-1).
  always_comb begin
    cnt = '0;
    for (int k = 1; k < MAX_BYTES; k++) begin
      if (|(mag >> (svc_pkg::HEAD_BITS + svc_pkg::CHUNK_W * (k - 1)))) begin
        cnt = IDX_W'(k);
      end
    end
  end

  assign vext  = EXT_W'(val);
  assign chunk = vext[svc_pkg::CHUNK_W * idx +: svc_pkg::CHUNK_W];

  always_comb begin
    if (head) begin
      enc_byte = {2'b01, val[VALUE_WIDTH-1], chunk[svc_pkg::HEAD_BITS-1:0]};
    end else begin
      enc_byte = {1'b1, chunk};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_val) begin
      val <= value_in[VALUE_WIDTH-1:0];
    end
    if (cmd.count) begin
      idx  <= cnt;
      head <= 1'b1;
    end else if (cmd.emit) begin
      head <= 1'b0;
      if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_comb begin
    acc_next   = acc;
    phase_next = phase;
    case (phase)
      svc_pkg::PH_HEAD: begin
        if (byte_in == svc_pkg::HEAD_ZERO) begin
          acc_next   = '0;
          phase_next = svc_pkg::PH_DONE;
        end else if (!byte_in[6]) begin
          acc_next   = '0;
          phase_next = svc_pkg::PH_ERR;
        end else begin
          acc_next   = VALUE_WIDTH'($signed(byte_in[5:0]));
          phase_next = svc_pkg::PH_CONT;
        end
      end
      svc_pkg::PH_CONT: begin
        if (byte_in[7]) begin
          acc_next = {acc[VALUE_WIDTH-8:0], byte_in[6:0]};
        end else begin
          phase_next = svc_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      phase <= svc_pkg::PH_HEAD;
    end else if (cmd.dec) begin
      if (segment_end) begin
        acc   <= '0;
        phase <= svc_pkg::PH_HEAD;
      end else begin
        acc   <= acc_next;
        phase <= phase_next;
      end
    end
  end

  // Output register; a new result loads only when the slot is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || (cmd.dec && segment_end)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind      <= svc_pkg::KIND_BYTE;
      byte_out  <= enc_byte;
      value_out <= '0;
      last      <= (idx == '0);
    end else if (cmd.dec && segment_end) begin
      byte_out <= '0;
      last     <= 1'b1;
      if (phase_next == svc_pkg::PH_ERR) begin
        kind      <= svc_pkg::KIND_ERROR;
        value_out <= '0;
      end else begin
        kind      <= svc_pkg::KIND_VALUE;
        value_out <= svc_pkg::DATA_W'($signed(acc_next));
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;
  assign sts.idx_zero = (idx == '0);

`ifndef SYNTHESIS
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.dec) |-> sts.out_free)
    else $error("result loaded while the output register is still full");
  a_decode_result: assert property (@(posedge clk) disable iff (rst)
    cmd.dec && segment_end |=> out_valid && last && kind != svc_pkg::KIND_BYTE)
    else $error("segment end did not produce a decode result");
  a_byte_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == svc_pkg::KIND_BYTE |-> byte_out[7] || byte_out[7:6] == 2'b01)
    else $error("encoded byte is neither a head nor a continuation byte");
`endif

endmodule

// ===== sv/signed_varint_codec.sv =====
// Top level of the signed varint codec: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries mode, value_in, byte_in and
// segment_end. Mode encode turns value_in into a head byte and up to
// MAX_BYTES-1 continuation bytes; mode decode takes one byte per transaction.
// The output channel (out_valid/out_ready) carries kind, byte_out, value_out
// and last through a single output register.
// Decode: one byte per cycle while the output register has room. The result
// for a segment appears in the output register in the cycle after the
// transaction that carries segment_end. Encode: an item is accepted, the byte
// count is computed from the magnitude, then one byte per cycle moves into the
// output register while it has room. A new item is accepted once the last byte
// is loaded. The single output register holds the flow back: a result only
// loads when the register is empty or being taken in the same cycle.
// Reset clears the state machine, the decode accumulator and phase, and
// the output valid flag. When the receiver stalls, in_ready drops and the
// encoder holds its current byte until the transaction completes.
module signed_varint_codec #(
  parameter int VALUE_WIDTH = svc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_BYTES   = svc_pkg::MAX_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [svc_pkg::DATA_W-1:0] value_in,
  input  logic [svc_pkg::BYTE_W-1:0] byte_in,
  input  logic                       segment_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [svc_pkg::BYTE_W-1:0] byte_out,
  output logic [svc_pkg::DATA_W-1:0] value_out,
  output logic                       last
);

  svc_pkg::cmd_t cmd;
  svc_pkg::sts_t sts;

  svc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  svc_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_BYTES   (MAX_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .value_in    (value_in),
    .byte_in     (byte_in),
    .segment_end (segment_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .byte_out    (byte_out),
    .value_out   (value_out),
    .last        (last)
  );

endmodule

// ===== sim/signed_varint_codec_tb.sv =====
// Self-checking testbench for the signed varint codec: encode bursts and decode segments.
`timescale 1ns / 1ps

module signed_varint_codec_tb;

  typedef struct {
    svc_pkg::kind_t                    kind;
    logic [svc_pkg::BYTE_W-1:0]        byte_val;
    logic [svc_pkg::DATA_W-1:0]        value;
    logic                              last_flag;
  } codec_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       mode = svc_pkg::MODE_ENCODE;
  logic [svc_pkg::DATA_W-1:0] value_in = '0;
  logic [svc_pkg::BYTE_W-1:0] byte_in = '0;
  logic                       segment_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 kind;
  logic [svc_pkg::BYTE_W-1:0] byte_out;
  logic [svc_pkg::DATA_W-1:0] value_out;
  logic                       last;

  codec_result_t              pending_results[$];
  svc_pkg::phase_t            dec_phase = svc_pkg::PH_HEAD;
  logic [svc_pkg::DATA_W-1:0] dec_acc = '0;
  int unsigned                mismatch_count = 0;
  int unsigned                items_sent = 0;
  int unsigned                stall_left = 0;
  bit                         quiet = 1'b0;

  signed_varint_codec u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .value_in   (value_in),
    .byte_in    (byte_in),
    .segment_end(segment_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .byte_out   (byte_out),
    .value_out  (value_out),
    .last       (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [svc_pkg::DATA_W-1:0] random_value();
    logic signed [svc_pkg::DATA_W-1:0] raw;
    raw = {$urandom, $urandom};
    return raw >>> $urandom_range(0, 63);
  endfunction

  // Head byte then 7-bit groups, most significant first.
  function automatic void vlq_bytes(input logic signed [svc_pkg::DATA_W-1:0] v,
                                    ref logic [svc_pkg::BYTE_W-1:0] seq[$]);
    logic [svc_pkg::DATA_W-1:0]        mag;
    logic signed [svc_pkg::DATA_W-1:0] part;
    int                                extra;
    seq.delete();
    mag = v[svc_pkg::DATA_W-1] ? (~v + 64'd1) : v;
    extra = 0;
    while (mag >= 64'd32) begin
      extra++;
      mag = mag >> svc_pkg::CHUNK_W;
    end
    if (extra > svc_pkg::MAX_BYTES_DEF - 1) extra = svc_pkg::MAX_BYTES_DEF - 1;
    part = v >>> (svc_pkg::CHUNK_W * extra);
    seq.push_back({2'b01, v[svc_pkg::DATA_W-1], part[svc_pkg::HEAD_BITS-1:0]});
    for (int i = extra - 1; i >= 0; i--) begin
      part = v >>> (svc_pkg::CHUNK_W * i);
      seq.push_back({1'b1, part[svc_pkg::CHUNK_W-1:0]});
    end
  endfunction

  function automatic void push_result(svc_pkg::kind_t k, logic [svc_pkg::BYTE_W-1:0] b,
                                      logic [svc_pkg::DATA_W-1:0] v, logic l);
    codec_result_t r;
    r.kind = k;
    r.byte_val = b;
    r.value = v;
    r.last_flag = l;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_transaction(input logic m,
                                              input logic [svc_pkg::DATA_W-1:0] v,
                                              input logic [svc_pkg::BYTE_W-1:0] b,
                                              input logic se);
    logic [svc_pkg::BYTE_W-1:0] seq[$];
    if (m == svc_pkg::MODE_ENCODE) begin
      vlq_bytes(v, seq);
      foreach (seq[i]) push_result(svc_pkg::KIND_BYTE, seq[i], '0, i == seq.size() - 1);
      return;
    end
    case (dec_phase)
      svc_pkg::PH_HEAD: begin
        if (b == svc_pkg::HEAD_ZERO) begin
          dec_acc = '0;
          dec_phase = svc_pkg::PH_DONE;
        end else if (!b[6]) begin
          dec_acc = '0;
          dec_phase = svc_pkg::PH_ERR;
        end else begin
          dec_acc = {{(svc_pkg::DATA_W-6){b[5]}}, b[5:0]};
          dec_phase = svc_pkg::PH_CONT;
        end
      end
      svc_pkg::PH_CONT: begin
        if (b[7]) dec_acc = {dec_acc[svc_pkg::DATA_W-8:0], b[6:0]};
        else dec_phase = svc_pkg::PH_DONE;
      end
      default: ;
    endcase
    if (se) begin
      if (dec_phase == svc_pkg::PH_ERR) push_result(svc_pkg::KIND_ERROR, '0, '0, 1'b1);
      else push_result(svc_pkg::KIND_VALUE, '0, dec_acc, 1'b1);
      dec_acc = '0;
      dec_phase = svc_pkg::PH_HEAD;
    end
  endfunction

  function automatic void check_field(string name, logic [svc_pkg::DATA_W-1:0] e,
                                      logic [svc_pkg::DATA_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      mismatch_count++;
    end
  endfunction

  // Output side: check each completed transaction, then pick the next ready level.
  always @(posedge clk) begin
    codec_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d byte %h value %h",
                 $time, kind, byte_out, value_out);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", svc_pkg::DATA_W'(want.kind), svc_pkg::DATA_W'(kind));
        check_field("byte_out", svc_pkg::DATA_W'(want.byte_val), svc_pkg::DATA_W'(byte_out));
        check_field("value_out", want.value, value_out);
        check_field("last", svc_pkg::DATA_W'(want.last_flag), svc_pkg::DATA_W'(last));
      end
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic m, input logic [svc_pkg::DATA_W-1:0] v,
                           input logic [svc_pkg::BYTE_W-1:0] b, input logic se);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    value_in    <= v;
    byte_in     <= b;
    segment_end <= se;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_transaction(m, v, b, se);
    items_sent++;
  endtask

  task automatic send_encode(input logic [svc_pkg::DATA_W-1:0] v);
    send_item(svc_pkg::MODE_ENCODE, v, svc_pkg::BYTE_W'($urandom),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_decode(input logic [svc_pkg::BYTE_W-1:0] b, input logic se);
    send_item(svc_pkg::MODE_DECODE, {$urandom, $urandom}, b, se);
  endtask

  // Holds the input side idle until every outstanding result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_encode_extremes();
    send_encode(64'd0);
    send_encode(-64'sd1);
    send_encode(64'd31);
    send_encode(64'd32);
    send_encode(-64'sd33);
    send_encode(64'h7FFF_FFFF_FFFF_FFFF);
    send_encode(64'h8000_0000_0000_0000);
    wait_drained();
  endtask

  task automatic test_decode_special_cases();
    // The zero head ignores whatever follows it in the segment.
    send_decode(svc_pkg::HEAD_ZERO, 1'b0);
    send_decode(8'hFF, 1'b0);
    send_decode(8'h85, 1'b1);
    // A head without bit 6, ended on the head itself.
    send_decode(8'hBF, 1'b1);
    // A byte without bit 7 closes the value; the rest is ignored.
    send_decode(8'h7F, 1'b0);
    send_decode(8'h81, 1'b0);
    send_decode(8'h05, 1'b0);
    send_decode(8'hFF, 1'b1);
    // An encode in the middle of a segment must leave the decode state alone.
    send_decode(8'h41, 1'b0);
    send_encode(64'd1000);
    send_decode(8'h82, 1'b1);
    // More groups than fit in 64 bits wrap around.
    send_decode(8'h5F, 1'b0);
    for (int i = 0; i < 9; i++) send_decode(8'hFF, i == 8);
    wait_drained();
  endtask

  task automatic test_random_mix();
    logic [svc_pkg::BYTE_W-1:0] seq[$];
    logic [svc_pkg::BYTE_W-1:0] tmp;
    int unsigned                r;
    int unsigned                n;
    int unsigned                k;
    bit                         mix;
    bit                         paused;
    paused = 1'b0;
    while (items_sent < 360) begin
      quiet = (items_sent >= 200 && items_sent < 260);
      if (!paused && items_sent >= 150) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_encode(random_value());
      end else if (r < 85) begin
        vlq_bytes(random_value(), seq);
        if ($urandom_range(0, 7) == 0) seq = {svc_pkg::HEAD_ZERO};
        if ($urandom_range(0, 3) == 0) begin
          tmp = svc_pkg::BYTE_W'($urandom);
          tmp[7] = 1'b0;
          seq.push_back(tmp);
          repeat ($urandom_range(0, 2)) begin
            tmp = svc_pkg::BYTE_W'($urandom);
            seq.push_back(tmp);
          end
        end
        mix = ($urandom_range(0, 5) == 0);
        k = $urandom_range(0, seq.size() - 1);
        foreach (seq[i]) begin
          if (mix && i == k) send_encode(random_value());
          send_decode(seq[i], i == seq.size() - 1);
        end
      end else begin
        // Noise: random bytes, sometimes shaped into long overflowing runs.
        n = $urandom_range(1, 12);
        mix = 1'($urandom_range(0, 1));
        for (int i = 0; i < n; i++) begin
          tmp = svc_pkg::BYTE_W'($urandom);
          if (mix) begin
            if (i == 0) tmp[6] = 1'b1;
            else tmp[7] = 1'b1;
          end
          send_decode(tmp, (i == n - 1) && ($urandom_range(0, 7) != 0));
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_extremes();
    test_decode_special_cases();
    test_random_mix();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
